// File: design/aba_pkg.sv
// Package for the arena block allocator.
// Holds the transaction payload types and the request, status and slot codes.
// No dependencies.
package aba_pkg;

  typedef enum logic [2:0] {
    KIND_ALLOC     = 3'd0,
    KIND_CALLOC    = 3'd1,
    KIND_FREE_B    = 3'd2,
    KIND_FREE_TOP  = 3'd3,
    KIND_FREE_ALL  = 3'd4,
    KIND_DECOMMIT  = 3'd5,
    KIND_INIT      = 3'd6,
    KIND_NOP       = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_BIG   = 2'd1,
    STAT_NO_SLOT   = 2'd2,
    STAT_NO_LIVE   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SLOT_UNUSED    = 2'd0,
    SLOT_LIVE      = 2'd1,
    SLOT_FREE      = 2'd2,
    SLOT_RSVD      = 2'd3
  } slot_e;

  localparam int unsigned SizeW = 13;
  localparam int unsigned StampW = 16;
  localparam int unsigned CountW = 5;
  localparam logic [SizeW-1:0] BlockSizeReset = 13'd4096;

  typedef struct packed {
    logic [2:0]       kind;
    logic [SizeW-1:0] size;
    logic [SizeW-1:0] count;
  } in_t;

  typedef struct packed {
    logic [15:0]       address;
    logic [SizeW-1:0]  amount;
    logic [1:0]        status;
    logic [CountW-1:0] live_blocks;
    logic [CountW-1:0] free_blocks;
  } out_t;

endpackage

// File: design/arena_block_allocator.sv
// Arena block allocator top level: sequencer plus slot-size, free-stamp and
// live-stack memories. Depends on aba_pkg.
//
// One transaction at a time. Free bytes that keeps the block, and alloc that
// fits the top block, run decode, top read, room check and done; freeing the
// top block reloads the head from the new top block's size, if any; an alloc that
// misses the top block scans every slot through the slot-size and free-stamp
// read ports; free all pops one live block at a time. Decommit, init and
// no-op go from decode to done. A finished result waits in the output
// register while the next request is taken. No clearing pass after reset.
module arena_block_allocator
  import aba_pkg::*;
#(
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned SLOT_BYTES = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i
);

  localparam int unsigned SW = $clog2(NUM_SLOTS);
  localparam int unsigned DW = $clog2(NUM_SLOTS + 1);
  localparam logic [16:0] SlotBytesW = 17'(SLOT_BYTES);
  localparam logic [31:0] SlotBytes32 = 32'(SLOT_BYTES);
  localparam logic [DW-1:0] NumSlotsD = DW'(NUM_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_TOP, S_ROOM, S_SCAN, S_PICK, S_NT1, S_NT2, S_NT3,
    S_FA1, S_FA2, S_DONE
  } state_e;

  state_e             state_q;
  logic [SizeW-1:0]   bs_q;
  logic [2:0]         kind_q;
  logic [SizeW-1:0]   size_q, req_q;
  logic [SizeW-1:0]   cnt_q;
  logic [SizeW-1:0]   head_q;
  logic [DW-1:0]      depth_q, nfree_q;
  logic [StampW-1:0]  stamp_q;
  logic [SW-1:0]      top_q;
  logic [1:0]         st_q [NUM_SLOTS];
  logic [SW:0]        sc_q;
  logic               cmp_v_q;
  logic [SW-1:0]      cmp_idx_q;
  logic               best_v_q, un_v_q;
  logic [SW-1:0]      best_idx_q, un_idx_q;
  logic [SizeW-1:0]   best_d_q;
  logic [StampW-1:0]  best_age_q;
  logic [15:0]        res_addr_q;
  logic [SizeW-1:0]   res_amt_q;
  logic [1:0]         res_st_q;
  logic               out_valid_q;
  out_t               out_q;

  logic [SizeW-1:0]   ss_mem [NUM_SLOTS];
  logic [StampW-1:0]  fs_mem [NUM_SLOTS];
  logic [SW-1:0]      ls_mem [NUM_SLOTS];
  logic [SizeW-1:0]   ss_rdata;
  logic [StampW-1:0]  fs_rdata;
  logic [SW-1:0]      ls_rdata;
  logic [SW-1:0]      ss_raddr, fs_raddr, ls_raddr, ss_waddr, fs_waddr, ls_waddr;
  logic               ss_we, fs_we, ls_we;
  logic [SizeW-1:0]   ss_wdata;
  logic [SW-1:0]      ls_wdata;

  logic [DW-1:0]      depth_m1;
  logic [SizeW-1:0]   need, room, cand_d;
  logic [StampW-1:0]  cand_age;
  logic [25:0]        prod;
  logic               too_big, fits, cand, better, pick_ok;
  logic [SW-1:0]      pick_s;
  logic [31:0]        top_base, pick_base;

  assign depth_m1  = depth_q - DW'(1);
  assign need      = (bs_q != '0) ? bs_q : req_q;
  assign room      = (head_q > ss_rdata) ? '0 : ss_rdata - head_q;
  assign prod      = 26'(kind_q == KIND_CALLOC ? cnt_q : 13'd0) * 26'(size_q);
  assign too_big   = ((bs_q != '0) && (req_q > bs_q)) || ({4'd0, need} > SlotBytesW);
  assign fits      = (depth_q != '0) && (req_q <= room);
  assign cand      = cmp_v_q && (st_q[cmp_idx_q] == SLOT_FREE) && (ss_rdata >= need);
  assign cand_d    = ss_rdata - need;
  assign cand_age  = stamp_q - fs_rdata;
  assign better    = !best_v_q || (cand_d < best_d_q) ||
                     ((cand_d == best_d_q) && (cand_age < best_age_q));
  assign pick_ok   = best_v_q || un_v_q;
  assign pick_s    = best_v_q ? best_idx_q : un_idx_q;
  assign top_base  = 32'(top_q) * SlotBytes32;
  assign pick_base = 32'(pick_s) * SlotBytes32;

  always_comb begin
    ss_raddr = top_q;
    fs_raddr = sc_q[SW-1:0];
    ls_raddr = depth_m1[SW-1:0];
    ss_we    = 1'b0;
    ss_waddr = pick_s;
    ss_wdata = need;
    fs_we    = 1'b0;
    fs_waddr = top_q;
    ls_we    = 1'b0;
    ls_waddr = depth_q[SW-1:0];
    ls_wdata = pick_s;
    unique case (state_q)
      S_TOP:  ss_raddr = ls_rdata;
      S_SCAN: ss_raddr = sc_q[SW-1:0];
      S_NT2:  ss_raddr = ls_rdata;
      S_DEC: begin
        if (kind_q == KIND_INIT && bs_q != '0 && {4'd0, bs_q} <= SlotBytesW) begin
          ss_we    = 1'b1;
          ss_waddr = '0;
          ss_wdata = bs_q;
          ls_we    = 1'b1;
          ls_waddr = '0;
          ls_wdata = '0;
        end
      end
      S_ROOM: begin
        fs_we = (kind_q == KIND_FREE_TOP || kind_q == KIND_FREE_B) &&
                (depth_q != '0) &&
                (kind_q == KIND_FREE_TOP || size_q >= head_q);
      end
      S_FA2: begin
        fs_we    = 1'b1;
        fs_waddr = ls_rdata;
      end
      S_PICK: begin
        ss_we = !best_v_q && un_v_q;
        ls_we = pick_ok && (depth_q < NumSlotsD);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ss_we) ss_mem[ss_waddr] <= ss_wdata;
    if (fs_we) fs_mem[fs_waddr] <= stamp_q;
    if (ls_we) ls_mem[ls_waddr] <= ls_wdata;
    ss_rdata <= ss_mem[ss_raddr];
    fs_rdata <= fs_mem[fs_raddr];
    ls_rdata <= ls_mem[ls_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bs_q        <= BlockSizeReset;
      kind_q      <= '0;
      size_q      <= '0;
      cnt_q       <= '0;
      req_q       <= '0;
      head_q      <= '0;
      depth_q     <= '0;
      nfree_q     <= '0;
      stamp_q     <= '0;
      top_q       <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) st_q[i] <= SLOT_UNUSED;
      sc_q        <= '0;
      cmp_v_q     <= 1'b0;
      cmp_idx_q   <= '0;
      best_v_q    <= 1'b0;
      un_v_q      <= 1'b0;
      best_idx_q  <= '0;
      un_idx_q    <= '0;
      best_d_q    <= '0;
      best_age_q  <= '0;
      res_addr_q  <= '0;
      res_amt_q   <= '0;
      res_st_q    <= STAT_OK;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) bs_q <= cfg_wdata_i;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q     <= in_data_i.kind;
            size_q     <= in_data_i.size;
            cnt_q      <= in_data_i.count;
            res_addr_q <= '0;
            res_amt_q  <= '0;
            res_st_q   <= STAT_OK;
            state_q    <= S_DEC;
          end
        end
        S_DEC: begin
          req_q   <= (kind_q == KIND_CALLOC) ?
                     ((|prod[25:13]) ? '1 : prod[12:0]) : size_q;
          state_q <= S_DONE;
          case (kind_q)
            KIND_ALLOC, KIND_CALLOC, KIND_FREE_B, KIND_FREE_TOP: state_q <= S_TOP;
            KIND_FREE_ALL: state_q <= S_FA1;
            KIND_DECOMMIT, KIND_INIT: begin
              for (int i = 0; i < NUM_SLOTS; i++) st_q[i] <= SLOT_UNUSED;
              depth_q <= '0;
              head_q  <= '0;
              nfree_q <= '0;
              if (kind_q == KIND_INIT) begin
                stamp_q <= '0;
                if (bs_q != '0) begin
                  if ({4'd0, bs_q} > SlotBytesW) begin
                    res_st_q <= STAT_TOO_BIG;
                  end else begin
                    st_q[0] <= SLOT_LIVE;
                    depth_q <= DW'(1);
                  end
                end
              end
            end
            default: ;
          endcase
        end
        S_TOP: begin
          top_q   <= ls_rdata;
          state_q <= S_ROOM;
        end
        S_ROOM: begin
          state_q <= S_DONE;
          if (kind_q == KIND_ALLOC || kind_q == KIND_CALLOC) begin
            if (too_big) begin
              res_st_q <= STAT_TOO_BIG;
            end else if (fits) begin
              res_addr_q <= top_base[15:0] + 16'(head_q);
              head_q     <= head_q + req_q;
            end else begin
              sc_q     <= '0;
              cmp_v_q  <= 1'b0;
              best_v_q <= 1'b0;
              un_v_q   <= 1'b0;
              state_q  <= S_SCAN;
            end
          end else if (depth_q == '0) begin
            res_st_q <= STAT_NO_LIVE;
          end else if (kind_q == KIND_FREE_B && size_q < head_q) begin
            head_q    <= head_q - size_q;
            res_amt_q <= size_q;
          end else begin
            if (kind_q == KIND_FREE_B) res_amt_q <= head_q;
            st_q[top_q] <= SLOT_FREE;
            stamp_q     <= stamp_q + StampW'(1);
            depth_q     <= depth_m1;
            nfree_q     <= nfree_q + DW'(1);
            state_q     <= S_NT1;
          end
        end
        S_SCAN: begin
          cmp_v_q   <= (sc_q < (SW+1)'(NUM_SLOTS));
          cmp_idx_q <= sc_q[SW-1:0];
          sc_q      <= sc_q + (SW+1)'(1);
          if (cand && better) begin
            best_v_q   <= 1'b1;
            best_idx_q <= cmp_idx_q;
            best_d_q   <= cand_d;
            best_age_q <= cand_age;
          end
          if (cmp_v_q && !un_v_q && st_q[cmp_idx_q] == SLOT_UNUSED) begin
            un_v_q   <= 1'b1;
            un_idx_q <= cmp_idx_q;
          end
          if (sc_q == (SW+1)'(NUM_SLOTS)) state_q <= S_PICK;
        end
        S_PICK: begin
          state_q <= S_DONE;
          if (!pick_ok) begin
            res_st_q <= STAT_NO_SLOT;
          end else begin
            if (best_v_q) nfree_q <= nfree_q - DW'(1);
            st_q[pick_s] <= SLOT_LIVE;
            if (depth_q < NumSlotsD) depth_q <= depth_q + DW'(1);
            res_addr_q <= pick_base[15:0];
            head_q     <= req_q;
          end
        end
        S_NT1: begin
          if (depth_q == '0) begin
            head_q  <= '0;
            state_q <= S_DONE;
          end else begin
            state_q <= S_NT2;
          end
        end
        S_NT2: state_q <= S_NT3;
        S_NT3: begin
          head_q  <= ss_rdata;
          state_q <= S_DONE;
        end
        S_FA1: begin
          if (depth_q == '0) begin
            head_q  <= '0;
            state_q <= S_DONE;
          end else begin
            state_q <= S_FA2;
          end
        end
        S_FA2: begin
          st_q[ls_rdata] <= SLOT_FREE;
          stamp_q        <= stamp_q + StampW'(1);
          depth_q        <= depth_m1;
          nfree_q        <= nfree_q + DW'(1);
          state_q        <= S_FA1;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q       <= 1'b1;
            out_q.address     <= res_addr_q;
            out_q.amount      <= res_amt_q;
            out_q.status      <= res_st_q;
            out_q.live_blocks <= CountW'(depth_q);
            out_q.free_blocks <= CountW'(nfree_q);
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
